/* rtl/core/rfc_pkg.sv */
package rfc_pkg;

    localparam int COLOR_W     = 8;
    localparam int PIX_W       = 3 * COLOR_W;
    localparam int POS_W       = 7;
    localparam int SIZE_W      = 8;
    localparam int EXT_W       = 8;
    localparam int SUM_W       = 9;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 40;

    localparam logic OP_DRAW = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [COLOR_W-1:0] WHITE_LEVEL = 8'd255;
    localparam logic [PIX_W-1:0]   WHITE       = {WHITE_LEVEL, WHITE_LEVEL, WHITE_LEVEL};

    typedef struct packed {
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
        logic [SIZE_W-1:0]  height;
        logic [SIZE_W-1:0]  width;
        logic [POS_W-1:0]   pos_y;
        logic [POS_W-1:0]   pos_x;
    } t_in_req;

    typedef struct packed {
        logic [EXT_W-1:0]   extent_y;
        logic [EXT_W-1:0]   extent_x;
        logic [COLOR_W-1:0] pixel_blue;
        logic [COLOR_W-1:0] pixel_green;
        logic [COLOR_W-1:0] pixel_red;
    } t_out_req;

endpackage

/* rtl/core/rectangle_fill_canvas.sv */
// Read request: accept, row read, output load.
// Draw request: mask setup, up to CANVAS_SIZE rows painted, output load; one canvas row
// is written per cycle through a per-pixel write mask on the row-wide memory.
// One request in work at a time; the next is accepted the cycle after the result
// is loaded, and that load can wait on output back-pressure.
// Reset clears the canvas to white row by row with tready low; extents zero.
module rectangle_fill_canvas #(
    parameter int CANVAS_SIZE = 128
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // pos_x[6:0], pos_y[13:7], width[21:14], height[29:22],
    // red[37:30], green[45:38], blue[53:46], zero fill[55:54]
    input  logic [rfc_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // op: 0 draw rectangle, 1 read pixel
    input  logic                               i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // pixel_red[7:0], pixel_green[15:8], pixel_blue[23:16],
    // extent_x[31:24], extent_y[39:32]
    output logic [rfc_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata
);
    import rfc_pkg::*;

    localparam int RW     = $clog2(CANVAS_SIZE);
    localparam int CSW    = $clog2(CANVAS_SIZE + 1);
    localparam int EW     = (CSW > SUM_W) ? CSW : SUM_W;
    localparam int ROW_W  = CANVAS_SIZE * PIX_W;
    localparam logic [EW-1:0] CS_E   = EW'(CANVAS_SIZE);
    localparam logic [EW-1:0] LAST_E = EW'(CANVAS_SIZE - 1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SETUP = 3'd2;
    localparam logic [2:0] ST_FILL  = 3'd3;
    localparam logic [2:0] ST_READ  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]             r_state, n_state;
    logic [EW-1:0]          r_row;
    logic                   r_op;
    logic [EW-1:0]          r_px;
    logic [EW-1:0]          r_py;
    logic [EW-1:0]          r_x1;
    logic [EW-1:0]          r_y1;
    logic [PIX_W-1:0]       r_color;
    logic [CANVAS_SIZE-1:0] r_mask;
    logic [EW-1:0]          r_max_right;
    logic [EW-1:0]          r_max_bottom;
    logic [ROW_W-1:0]       r_rdata;
    logic                   r_out_valid;
    t_out_req               r_out_data;

    logic [ROW_W-1:0]       r_mem [CANVAS_SIZE];

    t_in_req                in_req;
    logic                   in_accept;
    logic [EW-1:0]          sum_x, sum_y, clip_x, clip_y;
    logic                   row_active;
    logic                   mem_we;
    logic [RW-1:0]          mem_waddr;
    logic [CANVAS_SIZE-1:0] mem_wmask;
    logic [PIX_W-1:0]       mem_wcolor;
    logic [RW-1:0]          mem_raddr;
    logic [RW-1:0]          col_sel;
    logic [PIX_W-1:0]       pix_sel;
    logic                   out_load;
    t_out_req               out_next;

    assign in_req          = t_in_req'(i_s_axis_tdata[$bits(t_in_req)-1:0]);
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    // right and bottom edges, clipped to the canvas
    assign sum_x  = EW'({2'b00, in_req.pos_x}) + EW'({1'b0, in_req.width});
    assign sum_y  = EW'({2'b00, in_req.pos_y}) + EW'({1'b0, in_req.height});
    assign clip_x = (sum_x > CS_E) ? CS_E : sum_x;
    assign clip_y = (sum_y > CS_E) ? CS_E : sum_y;

    assign row_active = (r_row < r_y1);

    always_comb begin
        mem_we     = 1'b0;
        mem_wmask  = r_mask;
        mem_wcolor = r_color;
        if (r_state == ST_CLEAR) begin
            mem_we     = 1'b1;
            mem_wmask  = '1;
            mem_wcolor = WHITE;
        end else if (r_state == ST_FILL) begin
            mem_we = row_active;
        end
    end

    assign mem_waddr = r_row[RW-1:0];
    assign mem_raddr = r_py[RW-1:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            for (int c = 0; c < CANVAS_SIZE; c++) begin
                if (mem_wmask[c]) begin
                    r_mem[mem_waddr][c*PIX_W +: PIX_W] <= mem_wcolor;
                end
            end
        end
        r_rdata <= r_mem[mem_raddr];
    end

    assign col_sel = r_px[RW-1:0];
    assign pix_sel = r_rdata[col_sel*PIX_W +: PIX_W];

    always_comb begin
        out_next.extent_x    = r_max_right[EXT_W-1:0];
        out_next.extent_y    = r_max_bottom[EXT_W-1:0];
        out_next.pixel_red   = '0;
        out_next.pixel_green = '0;
        out_next.pixel_blue  = '0;
        // reads past the canvas edge return black
        if (r_op == OP_READ && r_px < CS_E && r_py < CS_E) begin
            out_next.pixel_red   = pix_sel[2*COLOR_W +: COLOR_W];
            out_next.pixel_green = pix_sel[COLOR_W +: COLOR_W];
            out_next.pixel_blue  = pix_sel[0 +: COLOR_W];
        end
    end

    assign out_load = (r_state == ST_DONE) && (!r_out_valid || i_m_axis_tready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (r_row == LAST_E) n_state = ST_IDLE;
            ST_IDLE: begin
                if (in_accept) n_state = (i_s_axis_tuser == OP_READ) ? ST_READ : ST_SETUP;
            end
            ST_SETUP: n_state = ST_FILL;
            ST_FILL:  if (!row_active) n_state = ST_DONE;
            ST_READ:  n_state = ST_DONE;
            ST_DONE:  if (out_load) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_row        <= '0;
            r_max_right  <= '0;
            r_max_bottom <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_row <= r_row + EW'(1);
            end else if (r_state == ST_SETUP) begin
                r_row <= r_py;
            end else if (r_state == ST_FILL && row_active) begin
                r_row <= r_row + EW'(1);
            end
            if (in_accept && i_s_axis_tuser == OP_DRAW) begin
                if (clip_x > r_max_right)  r_max_right  <= clip_x;
                if (clip_y > r_max_bottom) r_max_bottom <= clip_y;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op    <= i_s_axis_tuser;
            r_px    <= EW'(in_req.pos_x);
            r_py    <= EW'(in_req.pos_y);
            r_x1    <= clip_x;
            r_y1    <= clip_y;
            r_color <= {in_req.red, in_req.green, in_req.blue};
        end
        if (r_state == ST_SETUP) begin
            for (int c = 0; c < CANVAS_SIZE; c++) begin
                r_mask[c] <= (EW'(c) >= r_px) && (EW'(c) < r_x1);
            end
        end
        if (out_load) begin
            r_out_data <= out_next;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_TDATA_W'(r_out_data);

    a_extent_x_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_max_right >= $past(r_max_right))
        else $error("extent_x decreased");

    a_extent_clipped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_max_right <= CS_E && r_max_bottom <= CS_E)
        else $error("extent beyond canvas");

    a_fill_row_in_canvas: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FILL && mem_we) |-> r_row < CS_E)
        else $error("fill row outside canvas");

    a_read_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_s_axis_tuser == OP_READ) |=> r_state == ST_READ ##1 r_state == ST_DONE)
        else $error("read request left the read path");

    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready) |=> $stable(r_out_data))
        else $error("pending result overwritten");

endmodule

/* dv/rectangle_fill_canvas_test.sv */
module rectangle_fill_canvas_test;

    import rfc_pkg::*;

    localparam int CANVAS = 128;

    typedef struct {
        logic    op;
        t_in_req f;
        bit      drain;
    } canvas_req_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    // pos_x, pos_y, width, height, red, green, blue, zero fill
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata;
    // op
    logic                   i_s_axis_tuser;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    // pixel_red, pixel_green, pixel_blue, extent_x, extent_y
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;

    rectangle_fill_canvas #(.CANVAS_SIZE(CANVAS)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // shadow copy of the canvas, pixels held as {red, green, blue}
    logic [PIX_W-1:0] shadow_canvas [CANVAS][CANVAS];
    int               shadow_right;
    int               shadow_bottom;

    canvas_req_t pending_reqs[$];
    t_out_req    pending_results[$];

    int  mismatches = 0;
    bit  took_req = 1'b0;
    int  tx_gap = 0;
    int  rx_stall = 0;
    bit  tx_quiet = 1'b0;
    bit  rx_quiet = 1'b0;
    bit  drain_next = 1'b0;
    int  last_x = 0;
    int  last_y = 0;
    int  last_w = 0;
    int  last_h = 0;

    function automatic t_out_req canvas_apply(logic op, t_in_req f);
        t_out_req         res;
        int               right;
        int               bottom;
        logic [PIX_W-1:0] pix;
        res = '0;
        if (op == OP_DRAW) begin
            right  = int'(f.pos_x) + int'(f.width);
            bottom = int'(f.pos_y) + int'(f.height);
            if (right > CANVAS) right = CANVAS;
            if (bottom > CANVAS) bottom = CANVAS;
            for (int r = f.pos_y; r < bottom; r++)
                for (int c = f.pos_x; c < right; c++)
                    shadow_canvas[r][c] = {f.red, f.green, f.blue};
            if (right > shadow_right) shadow_right = right;
            if (bottom > shadow_bottom) shadow_bottom = bottom;
        end else begin
            pix = shadow_canvas[f.pos_y][f.pos_x];
            res.pixel_red   = pix[23:16];
            res.pixel_green = pix[15:8];
            res.pixel_blue  = pix[7:0];
        end
        res.extent_x = shadow_right[EXT_W-1:0];
        res.extent_y = shadow_bottom[EXT_W-1:0];
        return res;
    endfunction

    task automatic log_mismatch(string what, int got_v, int want_v);
        $display("mismatch %s: got %0d expected %0d", what, got_v, want_v);
        mismatches++;
    endtask

    function automatic int pick_gap(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // mostly small rectangles, a few up to the full canvas
    function automatic int pick_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return CANVAS;
        if (r < 15) return $urandom_range(0, CANVAS);
        return $urandom_range(0, 12);
    endfunction

    task automatic queue_req(logic op, int x, int y, int w, int h, int rd, int gr, int bl);
        canvas_req_t q;
        q.op       = op;
        q.f.pos_x  = x[POS_W-1:0];
        q.f.pos_y  = y[POS_W-1:0];
        q.f.width  = w[SIZE_W-1:0];
        q.f.height = h[SIZE_W-1:0];
        q.f.red    = rd[COLOR_W-1:0];
        q.f.green  = gr[COLOR_W-1:0];
        q.f.blue   = bl[COLOR_W-1:0];
        q.drain    = drain_next;
        drain_next = 1'b0;
        pending_reqs.push_back(q);
    endtask

    task automatic queue_draw(int x, int y, int w, int h, int rd, int gr, int bl);
        last_x = x;
        last_y = y;
        last_w = w;
        last_h = h;
        queue_req(OP_DRAW, x, y, w, h, rd, gr, bl);
    endtask

    // draw-only fields carry noise on reads
    task automatic queue_read(int x, int y);
        queue_req(OP_READ, x, y, $urandom_range(0, CANVAS), $urandom_range(0, CANVAS),
                  $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
    endtask

    // monitor: result check first, then record the accepted request
    always @(posedge i_clk) begin : monitor
        t_out_req got;
        t_out_req want;
        canvas_req_t acc;
        took_req = 1'b0;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = t_out_req'(o_m_axis_tdata);
                if (pending_results.size() == 0) begin
                    log_mismatch("result with none pending", 1, 0);
                end else begin
                    want = pending_results.pop_front();
                    if (got.pixel_red != want.pixel_red)
                        log_mismatch("pixel_red", got.pixel_red, want.pixel_red);
                    if (got.pixel_green != want.pixel_green)
                        log_mismatch("pixel_green", got.pixel_green, want.pixel_green);
                    if (got.pixel_blue != want.pixel_blue)
                        log_mismatch("pixel_blue", got.pixel_blue, want.pixel_blue);
                    if (got.extent_x != want.extent_x)
                        log_mismatch("extent_x", got.extent_x, want.extent_x);
                    if (got.extent_y != want.extent_y)
                        log_mismatch("extent_y", got.extent_y, want.extent_y);
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                took_req = 1'b1;
                acc.f  = t_in_req'(i_s_axis_tdata[$bits(t_in_req)-1:0]);
                acc.op = i_s_axis_tuser;
                pending_results.push_back(canvas_apply(acc.op, acc.f));
            end
        end
    end

    always @(negedge i_clk) begin : driver
        logic        nv;
        canvas_req_t nxt;
        nv = i_s_axis_tvalid;
        if (nv && took_req) nv = 1'b0;
        if (!i_rst_n) begin
            nv = 1'b0;
        end else if (!nv) begin
            if (tx_gap > 0) begin
                tx_gap--;
            end else if (pending_reqs.size() > 0 &&
                         !(pending_reqs[0].drain && pending_results.size() > 0)) begin
                nxt = pending_reqs.pop_front();
                i_s_axis_tdata <= {{(IN_TDATA_W - $bits(t_in_req)){1'b0}}, nxt.f};
                i_s_axis_tuser <= nxt.op;
                nv = 1'b1;
                if ($urandom_range(0, 63) == 0) tx_quiet = !tx_quiet;
                tx_gap = pick_gap(tx_quiet);
            end
        end
        i_s_axis_tvalid <= nv;
    end

    always @(negedge i_clk) begin : receiver
        if (rx_stall > 0) begin
            rx_stall--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
            if ($urandom_range(0, 255) == 0) rx_quiet = !rx_quiet;
            if ($urandom_range(0, 5) == 0) rx_stall = pick_gap(rx_quiet);
        end
    end

    initial begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        int x;
        int y;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = OP_DRAW;
        i_m_axis_tready = 1'b0;
        for (int r = 0; r < CANVAS; r++)
            for (int c = 0; c < CANVAS; c++)
                shadow_canvas[r][c] = WHITE;
        shadow_right  = 0;
        shadow_bottom = 0;

        // fresh canvas reads white with zero extent
        queue_read(0, 0);
        queue_read(127, 127);
        // empty rectangles still move the extent
        queue_draw(0, 0, 0, 0, 17, 34, 51);
        queue_draw(5, 7, 0, 20, 1, 2, 3);
        queue_read(5, 7);
        queue_draw(0, 0, 128, 128, 255, 0, 0);
        queue_read(127, 127);
        // corner pixel, rest clipped
        queue_draw(127, 127, 128, 128, 0, 255, 0);
        queue_read(127, 127);
        queue_read(126, 126);
        queue_draw(100, 20, 50, 1, 170, 85, 1);
        queue_read(127, 20);
        queue_read(99, 20);
        queue_read(100, 21);
        queue_draw(1, 2, 1, 1, 0, 0, 0);
        queue_read(1, 2);
        queue_draw(64, 64, 3, 3, 255, 255, 255);
        queue_read(66, 66);
        queue_read(67, 67);
        queue_draw(127, 0, 1, 128, 128, 64, 32);
        queue_read(127, 64);
        queue_draw(0, 127, 128, 1, 85, 170, 254);
        queue_read(50, 127);

        // hold off until the directed part has fully drained
        drain_next = 1'b1;
        for (int n = 0; n < 1250; n++) begin
            if ($urandom_range(0, 99) == 0) drain_next = 1'b1;
            if ($urandom_range(0, 1) == 0) begin
                queue_draw($urandom_range(0, 127), $urandom_range(0, 127),
                           pick_span(), pick_span(), $urandom_range(0, 255),
                           $urandom_range(0, 255), $urandom_range(0, 255));
            end else if ($urandom_range(0, 9) < 6) begin
                // aim at the latest rectangle so reads see painted pixels
                x = last_x + $urandom_range(0, last_w);
                y = last_y + $urandom_range(0, last_h);
                queue_read(x > 127 ? 127 : x, y > 127 ? 127 : y);
            end else begin
                queue_read($urandom_range(0, 127), $urandom_range(0, 127));
            end
        end

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() > 0 || i_s_axis_tvalid || pending_results.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
